// ===== rtl/core/ppsch_pkg.sv =====
// shared types and codes for the preemptive priority scheduler
package ppsch_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // result status codes carried on m_tuser
    localparam logic [2:0] ST_LOADED = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_ZERO   = 3'd2;
    localparam logic [2:0] ST_RAN    = 3'd3;
    localparam logic [2:0] ST_IDLE   = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 112;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_CALC,
        FSM_EMIT
    } fsm_t;

    // one loaded task
    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] arrival;
        logic [7:0]  id;
    } task_t;

    // best candidate so far, handed from cell to cell
    typedef struct packed {
        logic        found;
        logic [15:0] rem;
        task_t       info;
    } cand_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic        clear;
        logic [31:0] tick;
        task_t       wdata;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// top level of the preemptive priority scheduler: control, result register and cell chain
//
// usage:
//   s_ channel carries one command transaction: s_tuser selects load (0), tick (1)
//   or clear (2, 3); s_tdata holds the task fields for a load
//   m_ channel returns exactly one result transaction per command, status on m_tuser
// timing:
//   load and clear: state updates on the accept edge, the result passes through the
//   emit state, and the next command can be taken once the result is valid
//   tick: the candidate travels down the row of MAX_TASKS cells, one cell per cycle,
//   then the calc state picks and charges the winner, the emit state writes it out,
//   so the time to a tick result grows with the chain length
//   one command is in work at a time; a new command is taken once the previous
//   one has been written into the result register
// stall:
//   while m_tready is low the result register holds; the next command may still
//   be accepted and worked, and waits for the register before it is written out
// reset:
//   aresetn low clears the task count, done count, clock and every remaining
//   counter; stored task fields stay undefined until loaded
module preemptive_priority_scheduler import ppsch_pkg::*; #(
    parameter int MAX_TASKS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // task_id[7:0], arrival_time[23:8], burst_length[39:24], task_priority[47:40]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // running_id[7:0], finished[8], finish_time[40:9], turnaround[72:41],
    // waiting[104:73], all_done[105], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [2:0]           m_tuser
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    fsm_t             state_reg;
    fsm_t             state_next;

    logic [CNT_W-1:0] task_count_reg;
    logic [CNT_W-1:0] done_count_reg;
    logic [31:0]      tick_reg;
    logic [IDX_W-1:0] scan_cnt_reg;

    // result being assembled
    logic [2:0]       res_status_reg;
    logic [7:0]       res_id_reg;
    logic             res_fin_reg;
    logic [31:0]      res_ft_reg;
    logic [31:0]      res_tat_reg;
    logic [15:0]      res_burst_reg;

    logic             m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [2:0]       m_tuser_reg;

    logic             s_accept;
    logic             scan_done;
    logic             emit_go;
    logic             load_we;
    logic             clear_en;
    logic             calc_en;
    task_t            in_task;
    logic             table_full;
    logic             win_fin;
    logic [31:0]      waiting_w;

    cell_ctrl_t       ctrl;
    cand_t            cand_w [0:MAX_TASKS];
    logic [IDX_W-1:0] idx_w  [0:MAX_TASKS];
    logic [MAX_TASKS-1:0] we_w;
    logic [MAX_TASKS-1:0] grant_w;

    assign in_task.id      = s_tdata[7:0];
    assign in_task.arrival = s_tdata[23:8];
    assign in_task.burst   = s_tdata[39:24];
    assign in_task.prio    = s_tdata[47:40];

    assign s_accept   = s_tvalid && s_tready;
    assign table_full = (task_count_reg == CNT_W'(MAX_TASKS));
    assign scan_done  = (scan_cnt_reg == IDX_W'(MAX_TASKS - 1));
    assign win_fin    = cand_w[MAX_TASKS].found && (cand_w[MAX_TASKS].rem == 16'd1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == KIND_TICK) ? FSM_SCAN : FSM_EMIT;
                end
            end
            FSM_SCAN: begin
                if (scan_done) begin
                    state_next = FSM_CALC;
                end
            end
            FSM_CALC: state_next = FSM_EMIT;
            FSM_EMIT: begin
                if (emit_go) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = 1'b0;
        load_we  = 1'b0;
        clear_en = 1'b0;
        calc_en  = 1'b0;
        emit_go  = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    case (s_tuser)
                        KIND_LOAD: load_we = !table_full && (in_task.burst != 16'd0);
                        KIND_TICK: ;
                        default:   clear_en = 1'b1;
                    endcase
                end
            end
            FSM_SCAN: ;
            FSM_CALC: calc_en = 1'b1;
            FSM_EMIT: emit_go = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // bookkeeping registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= '0;
            done_count_reg <= '0;
            tick_reg       <= '0;
            scan_cnt_reg   <= '0;
        end else begin
            if (clear_en) begin
                task_count_reg <= '0;
                done_count_reg <= '0;
                tick_reg       <= '0;
            end
            if (load_we) begin
                task_count_reg <= task_count_reg + CNT_W'(1);
            end
            if (calc_en) begin
                tick_reg <= tick_reg + 32'd1;
                if (win_fin) begin
                    done_count_reg <= done_count_reg + CNT_W'(1);
                end
            end
            if (state_reg == FSM_SCAN) begin
                scan_cnt_reg <= scan_done ? '0 : scan_cnt_reg + IDX_W'(1);
            end
        end
    end

    // result assembly
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_id_reg    <= '0;
            res_fin_reg   <= 1'b0;
            res_ft_reg    <= '0;
            res_tat_reg   <= '0;
            res_burst_reg <= '0;
            case (s_tuser)
                KIND_LOAD: begin
                    if (table_full) begin
                        res_status_reg <= ST_FULL;
                    end else if (in_task.burst == 16'd0) begin
                        res_status_reg <= ST_ZERO;
                    end else begin
                        res_status_reg <= ST_LOADED;
                    end
                end
                KIND_TICK: res_status_reg <= ST_IDLE;
                default:   res_status_reg <= ST_CLEAR;
            endcase
        end else if (calc_en && cand_w[MAX_TASKS].found) begin
            res_status_reg <= ST_RAN;
            res_id_reg     <= cand_w[MAX_TASKS].info.id;
            res_fin_reg    <= win_fin;
            if (win_fin) begin
                res_ft_reg    <= tick_reg + 32'd1;
                res_tat_reg   <= tick_reg - {16'd0, cand_w[MAX_TASKS].info.arrival} + 32'd1;
                res_burst_reg <= cand_w[MAX_TASKS].info.burst;
            end
        end
    end

    assign waiting_w = res_tat_reg - {16'd0, res_burst_reg};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {6'd0,
                            (done_count_reg == task_count_reg),
                            waiting_w,
                            res_tat_reg,
                            res_ft_reg,
                            res_fin_reg,
                            res_id_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // cell chain: an empty candidate enters cell 0, the winner leaves the last cell
    assign ctrl.clear = clear_en;
    assign ctrl.tick  = tick_reg;
    assign ctrl.wdata = in_task;

    assign cand_w[0] = '0;
    assign idx_w[0]  = '0;

    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        assign we_w[i]    = load_we && (task_count_reg == CNT_W'(i));
        assign grant_w[i] = calc_en && cand_w[MAX_TASKS].found
                         && (idx_w[MAX_TASKS] == IDX_W'(i));

        ppsch_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .we       (we_w[i]),
            .grant_en (grant_w[i]),
            .in_cand  (cand_w[i]),
            .in_idx   (idx_w[i]),
            .out_cand (cand_w[i+1]),
            .out_idx  (idx_w[i+1])
        );
    end

    // completed tasks never outnumber loaded ones
    a_done_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        done_count_reg <= task_count_reg)
        else $error("done count exceeds task count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        task_count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count beyond table size");

    // a finishing grant bumps the done count
    a_fin_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (calc_en && win_fin) |=> (done_count_reg == $past(done_count_reg) + CNT_W'(1)))
        else $error("finish not counted");

    // a new result only appears out of the emit step
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == FSM_EMIT))
        else $error("result raised outside emit");

    // a tick always spends the full scan before its grant
    a_calc_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_CALC) |-> $past(state_reg == FSM_SCAN && scan_done))
        else $error("grant without a full scan");

endmodule

// ===== rtl/core/ppsch_cell.sv =====
// one scheduler cell: holds a task slot and compares it against the passing candidate
module ppsch_cell import ppsch_pkg::*; #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  logic             we,
    input  logic             grant_en,
    input  cand_t            in_cand,
    input  logic [IDX_W-1:0] in_idx,
    output cand_t            out_cand,
    output logic [IDX_W-1:0] out_idx
);

    task_t            info_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      rem_next;
    cand_t            cand_reg;
    cand_t            cand_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             eligible;
    logic             better;

    always_ff @(posedge aclk) begin
        if (we) begin
            info_reg <= ctrl.wdata;
        end
    end

    always_comb begin
        rem_next = rem_reg;
        if (ctrl.clear) begin
            rem_next = '0;
        end else if (we) begin
            rem_next = ctrl.wdata.burst;
        end else if (grant_en) begin
            rem_next = rem_reg - 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    // strict compare keeps the lower slot on a full tie
    assign eligible = (rem_reg != 16'd0) && ({16'd0, info_reg.arrival} <= ctrl.tick);
    assign better   = !in_cand.found
                   || (info_reg.prio < in_cand.info.prio)
                   || ((info_reg.prio == in_cand.info.prio)
                       && (info_reg.arrival < in_cand.info.arrival));

    always_comb begin
        cand_next = in_cand;
        idx_next  = in_idx;
        if (eligible && better) begin
            cand_next.found = 1'b1;
            cand_next.rem   = rem_reg;
            cand_next.info  = info_reg;
            idx_next        = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg.found <= 1'b0;
        end else begin
            cand_reg.found <= cand_next.found;
        end
        cand_reg.rem  <= cand_next.rem;
        cand_reg.info <= cand_next.info;
        idx_reg       <= idx_next;
    end

    assign out_cand = cand_reg;
    assign out_idx  = idx_reg;

endmodule

// ===== dv/tb_preemptive_priority_scheduler.sv =====
// self-checking testbench for the preemptive priority scheduler
module tb_preemptive_priority_scheduler;
    import ppsch_pkg::*;

    localparam int MAX_TASKS   = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 60;
    localparam int TARGET_CMDS = 1525;

    // any kind other than load or tick is decoded as a clear, so this acts as a clear
    localparam logic [1:0] KIND_CLEAR_ALT = 2'd3;

    typedef struct packed {
        logic        hold_until_idle;
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } sched_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  running_id;
        logic        finished;
        logic [31:0] finish_time;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic        all_done;
    } sched_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = KIND_TICK;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0]           m_tuser;

    sched_cmd_t    cmd_backlog[$];
    sched_result_t predicted_outcomes[$];

    // scheduler state as the predictor sees it
    task_t         sched_tasks[MAX_TASKS];
    logic [15:0]   sched_left[MAX_TASKS];
    logic [4:0]    sched_count = '0;
    logic [4:0]    sched_done  = '0;
    logic [31:0]   sched_clock = '0;

    int unsigned   mismatches  = 0;
    int unsigned   cycle_count = 0;
    int unsigned   send_gap    = 0;
    int unsigned   ready_stall = 0;
    bit            cmd_taken   = 1'b0;
    bit            calm_send   = 1'b0;
    bit            calm_recv   = 1'b0;

    preemptive_priority_scheduler #(
        .MAX_TASKS(MAX_TASKS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one command against the predictor state, returns the result it must produce
    function automatic sched_result_t predict_outcome(sched_cmd_t c);
        sched_result_t r;
        bit            found;
        int            pick;
        int            i;
        logic [31:0]   tat;
        r     = '0;
        found = 1'b0;
        pick  = 0;
        if (c.kind[1]) begin
            sched_count = '0;
            sched_done  = '0;
            sched_clock = '0;
            for (i = 0; i < MAX_TASKS; i++) sched_left[i] = '0;
            r.status = ST_CLEAR;
        end else if (c.kind[0]) begin
            // lowest priority value wins, then earlier arrival, then lower slot
            for (i = 0; i < MAX_TASKS; i++) begin
                if (i < sched_count && sched_left[i] != 16'd0 &&
                    {16'd0, sched_tasks[i].arrival} <= sched_clock) begin
                    if (!found || sched_tasks[i].prio < sched_tasks[pick].prio ||
                        (sched_tasks[i].prio == sched_tasks[pick].prio &&
                         sched_tasks[i].arrival < sched_tasks[pick].arrival)) begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
            end
            sched_clock = sched_clock + 32'd1;
            if (!found) begin
                r.status = ST_IDLE;
            end else begin
                r.status       = ST_RAN;
                r.running_id   = sched_tasks[pick].id;
                sched_left[pick] = sched_left[pick] - 16'd1;
                if (sched_left[pick] == 16'd0) begin
                    tat           = sched_clock - {16'd0, sched_tasks[pick].arrival};
                    sched_done    = sched_done + 5'd1;
                    r.finished    = 1'b1;
                    r.finish_time = sched_clock;
                    r.turnaround  = tat;
                    r.waiting     = tat - {16'd0, sched_tasks[pick].burst};
                end
            end
        end else begin
            // a full table is reported ahead of a zero burst
            if (sched_count == MAX_TASKS) begin
                r.status = ST_FULL;
            end else if (c.burst == 16'd0) begin
                r.status = ST_ZERO;
            end else begin
                sched_tasks[sched_count].id      = c.id;
                sched_tasks[sched_count].arrival = c.arrival;
                sched_tasks[sched_count].burst   = c.burst;
                sched_tasks[sched_count].prio    = c.prio;
                sched_left[sched_count]          = c.burst;
                sched_count                      = sched_count + 5'd1;
                r.status                         = ST_LOADED;
            end
        end
        r.all_done = (sched_done == sched_count);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_cmd(logic [1:0] kind, logic [7:0] id, logic [15:0] arrival,
                           logic [15:0] burst, logic [7:0] prio, bit hold);
        sched_cmd_t c;
        c.hold_until_idle = hold;
        c.kind            = kind;
        c.id              = id;
        c.arrival         = arrival;
        c.burst           = burst;
        c.prio            = prio;
        cmd_backlog = {cmd_backlog, c};
    endtask

    task automatic add_load(logic [7:0] id, logic [15:0] arrival, logic [15:0] burst,
                            logic [7:0] prio);
        add_cmd(KIND_LOAD, id, arrival, burst, prio, 1'b0);
    endtask

    task automatic add_filler(logic [1:0] kind, bit hold);
        add_cmd(kind, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), hold);
    endtask

    // predictor and checker: both sides sampled at the rising edge
    always @(posedge aclk) begin
        sched_result_t want;
        sched_result_t got;
        sched_cmd_t    c;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                c.hold_until_idle = 1'b0;
                c.kind            = s_tuser;
                {c.prio, c.burst, c.arrival, c.id} = s_tdata;
                predicted_outcomes = {predicted_outcomes, predict_outcome(c)};
                cmd_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (predicted_outcomes.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    mismatches++;
                end else begin
                    want            = predicted_outcomes.pop_front();
                    got.status      = m_tuser;
                    got.running_id  = m_tdata[7:0];
                    got.finished    = m_tdata[8];
                    got.finish_time = m_tdata[40:9];
                    got.turnaround  = m_tdata[72:41];
                    got.waiting     = m_tdata[104:73];
                    got.all_done    = m_tdata[105];
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("running_id", 32'(want.running_id), 32'(got.running_id));
                    check_field("finished", 32'(want.finished), 32'(got.finished));
                    check_field("finish_time", want.finish_time, got.finish_time);
                    check_field("turnaround", want.turnaround, got.turnaround);
                    check_field("waiting", want.waiting, got.waiting);
                    check_field("all_done", 32'(want.all_done), 32'(got.all_done));
                    check_field("tdata_pad", 32'd0, 32'(m_tdata[M_TDATA_W-1:106]));
                end
            end
        end
    end

    // command driver, changes inputs on the falling edge
    always @(negedge aclk) begin
        sched_cmd_t c;
        if (aresetn && (!s_tvalid || cmd_taken)) begin
            cmd_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].hold_until_idle &&
                           predicted_outcomes.size() != 0)) begin
                c = cmd_backlog.pop_front();
                s_tuser  <= c.kind;
                s_tdata  <= {c.prio, c.burst, c.arrival, c.id};
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 49) == 0) calm_send = !calm_send;
                send_gap = pick_gap(calm_send);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if ($urandom_range(0, 499) == 0) calm_recv = !calm_recv;
        if (ready_stall > 0) begin
            ready_stall--;
            m_tready <= 1'b0;
        end else begin
            ready_stall = ($urandom_range(0, 99) < 30) ? pick_gap(calm_recv) : 0;
            m_tready <= (ready_stall == 0);
        end
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("tb_preemptive_priority_scheduler failed");
        $finish;
    end

    initial begin
        int unsigned n_tasks;
        int unsigned max_arr;
        int unsigned work;
        int unsigned n_ticks;
        int unsigned pct;
        int unsigned t;
        int unsigned k;
        bit          wide_prio;
        bit          first_round;
        logic [15:0] burst;

        // empty table, field extremes, a rejected load and the kind 3 clear
        add_filler(KIND_TICK, 1'b0);
        add_load(8'hFF, 16'h0000, 16'h0001, 8'h00);
        add_load(8'h00, 16'hFFFF, 16'hFFFF, 8'hFF);
        add_load(8'h07, 16'h0003, 16'h0000, 8'h01);
        add_filler(KIND_TICK, 1'b0);
        add_filler(KIND_TICK, 1'b0);
        add_filler(KIND_CLEAR_ALT, 1'b0);
        // priority ties: earlier arrival first, then lower slot
        add_load(8'h01, 16'd2, 16'd2, 8'd5);
        add_load(8'h02, 16'd1, 16'd1, 8'd5);
        add_load(8'h03, 16'd1, 16'd2, 8'd5);
        add_load(8'h04, 16'd0, 16'd1, 8'd9);
        for (k = 0; k < 7; k++) add_filler(KIND_TICK, 1'b0);
        // late load arrives in the past, so it is ready at once
        add_load(8'h05, 16'd0, 16'd2, 8'd0);
        add_filler(KIND_TICK, 1'b0);
        add_filler(KIND_TICK, 1'b0);
        add_filler(KIND_CLEAR, 1'b0);

        first_round = 1'b1;
        while (cmd_backlog.size() < TARGET_CMDS) begin
            if (!first_round && $urandom_range(0, 99) < 15) begin
                // noise: any kind, any field values
                n_ticks = $urandom_range(1, 8);
                for (k = 0; k < n_ticks; k++) add_filler(2'($urandom_range(0, 3)), 1'b0);
            end else begin
                // well-formed round: clear, load a table, then run ticks on it
                add_filler(($urandom_range(0, 9) == 0) ? KIND_CLEAR_ALT : KIND_CLEAR,
                           first_round || $urandom_range(0, 9) == 0);
                n_tasks   = (first_round || $urandom_range(0, 3) == 0) ?
                            MAX_TASKS : $urandom_range(1, MAX_TASKS - 1);
                max_arr   = $urandom_range(0, 12);
                wide_prio = $urandom_range(0, 1);
                work      = 0;
                for (k = 0; k < n_tasks; k++) begin
                    pct = $urandom_range(0, 99);
                    if (pct < 4) begin
                        burst = 16'd0;
                    end else if (pct < 6) begin
                        burst = 16'($urandom_range(1, 65535));
                    end else begin
                        burst = 16'($urandom_range(1, 6));
                        work  = work + burst;
                    end
                    add_load(8'($urandom), 16'($urandom_range(0, max_arr)), burst,
                             wide_prio ? 8'($urandom_range(0, 255)) :
                                         8'($urandom_range(0, 3)));
                end
                if (n_tasks == MAX_TASKS) begin
                    // loads into a full table, one of them with a zero burst
                    add_load(8'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
                             8'($urandom));
                    add_load(8'($urandom), 16'($urandom), 16'd0, 8'($urandom));
                end
                n_ticks = work + max_arr + $urandom_range(0, 4);
                if (n_ticks > 150) n_ticks = 150;
                for (t = 0; t < n_ticks; t++) begin
                    if ($urandom_range(0, 19) == 0)
                        add_load(8'($urandom), 16'($urandom_range(0, t)),
                                 16'($urandom_range(1, 4)), 8'($urandom_range(0, 7)));
                    add_filler(KIND_TICK, 1'b0);
                end
                first_round = 1'b0;
            end
        end

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        while (!(cmd_backlog.size() == 0 && !s_tvalid && predicted_outcomes.size() == 0))
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0 && predicted_outcomes.size() == 0) begin
            $display("tb_preemptive_priority_scheduler passed");
        end else begin
            $display("tb_preemptive_priority_scheduler failed");
        end
        $finish;
    end

endmodule
